>>> rtl/weekday_count_between_dates_unit_assert.svh
// Assertion macros for the weekday count unit.
// Expects clk and rst_n in scope at the place of use; no other dependencies.
`ifndef WEEKDAY_COUNT_BETWEEN_DATES_UNIT_ASSERT_SVH
`define WEEKDAY_COUNT_BETWEEN_DATES_UNIT_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define WDCB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wdcb assertion failed");

// Next-cycle implication, off while in reset.
`define WDCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wdcb assertion failed");

`endif

>>> rtl/wdcb_pkg.sv
// Shared types, constants and calendar tables for the weekday count unit.
// No dependencies; imported by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps

package wdcb_pkg;

    // Field widths
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned SERIAL_W = 22;
    localparam int unsigned MUL_W    = 2 * SERIAL_W;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned MOFF_W   = 9;

    // Divide-by-25 unit (operand is a year over 4, result is at most 163)
    localparam int unsigned D25_W  = YEAR_W - 2;
    localparam int unsigned Q25_W  = 8;
    localparam int unsigned R25_W  = 5;
    localparam int unsigned SHIFT25 = 16;

    // Divide-by-7 unit (operand is a biased serial day number)
    localparam int unsigned Q7_W   = 20;
    localparam int unsigned R7_W   = 3;
    localparam int unsigned SHIFT7 = 24;

    localparam logic [YEAR_W-1:0]   MAX_YEAR = 14'd9999;
    // floor(2^16 / 25) and floor(2^24 / 7); one correction step restores exactness
    localparam logic [SERIAL_W-1:0] RECIP25  = 22'd2621;
    localparam logic [SERIAL_W-1:0] RECIP7   = 22'd2396745;
    localparam logic [SERIAL_W-1:0] DIV25    = 22'd25;
    localparam logic [SERIAL_W-1:0] DIV7     = 22'd7;
    localparam logic [SERIAL_W-1:0] DAYS_YEAR = 22'd365;
    localparam logic [SERIAL_W-1:0] WEEK_DAYS = 22'd5;
    // Day of month minus one, plus 3 so that the serial number mod 7 is the
    // day of week with Sunday as 0 (serial day 0 is a Wednesday)
    localparam logic [SERIAL_W-1:0] SERIAL_BIAS = 22'd2;

    // Jump targets in the control program
    localparam logic [STEP_W-1:0] STEP_DATE_LOOP  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FLOOR_LOOP = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FINISH     = 4'd11;

    typedef struct packed {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
    } req_t;

    typedef struct packed {
        logic [SERIAL_W-1:0] weekday_total;
        logic                date_invalid;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_LEAP_MUL,
        OP_DIV25_FIX,
        OP_CHECK,
        OP_SER_MUL,
        OP_SER_BASE,
        OP_SER_ADD,
        OP_ORDER,
        OP_D7_MUL,
        OP_D7_FIX,
        OP_F_ACC,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        SEL_KEEP,
        SEL_SET,
        SEL_TOGGLE
    } sel_ctl_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_SEL0,
        JC_SEL1,
        JC_BAD
    } jcond_t;

    typedef struct packed {
        op_t               op;
        sel_ctl_t          sel_ctl;
        jcond_t            jcond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t      op;
        sel_ctl_t sel_ctl;
        logic     exec;
        logic     load;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic sel;
        logic bad;
        logic out_free;
    } status_t;

    // Month length; 0 for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days from March 1 to the first of the month, year starting in March
    function automatic logic [MOFF_W-1:0] march_offset(input logic [MONTH_W-1:0] month);
        logic [MOFF_W-1:0] off;
        case (month)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

>>> rtl/wdcb_seq.sv
// Microcode sequencer: control ROM, step counter, conditional jumps.
// Depends on wdcb_pkg; drives the datapath through ctrl_t.
`timescale 1ns / 1ps

module wdcb_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  wdcb_pkg::status_t status,
    output wdcb_pkg::ctrl_t   ctrl
);
    import wdcb_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              stall;
    logic              taken;
    logic              load;

    // Control program: one pass per date, then two passes of the week floor
    always_comb
    begin
        word = '{op: OP_DONE, sel_ctl: SEL_KEEP, jcond: JC_NONE, target: '0, last: 1'b1};
        case (step_reg)
            4'd0:  word = '{OP_LEAP_MUL,  SEL_KEEP,   JC_NONE, '0, 1'b0};
            4'd1:  word = '{OP_DIV25_FIX, SEL_KEEP,   JC_NONE, '0, 1'b0};
            4'd2:  word = '{OP_CHECK,     SEL_KEEP,   JC_NONE, '0, 1'b0};
            4'd3:  word = '{OP_SER_MUL,   SEL_KEEP,   JC_BAD,  STEP_FINISH, 1'b0};
            4'd4:  word = '{OP_DIV25_FIX, SEL_KEEP,   JC_NONE, '0, 1'b0};
            4'd5:  word = '{OP_SER_BASE,  SEL_KEEP,   JC_NONE, '0, 1'b0};
            4'd6:  word = '{OP_SER_ADD,   SEL_TOGGLE, JC_SEL0, STEP_DATE_LOOP, 1'b0};
            4'd7:  word = '{OP_ORDER,     SEL_SET,    JC_NONE, '0, 1'b0};
            4'd8:  word = '{OP_D7_MUL,    SEL_KEEP,   JC_NONE, '0, 1'b0};
            4'd9:  word = '{OP_D7_FIX,    SEL_KEEP,   JC_NONE, '0, 1'b0};
            4'd10: word = '{OP_F_ACC,     SEL_TOGGLE, JC_SEL1, STEP_FLOOR_LOOP, 1'b0};
            4'd11: word = '{OP_DONE,      SEL_KEEP,   JC_NONE, '0, 1'b1};
            default: word = '{OP_DONE,    SEL_KEEP,   JC_NONE, '0, 1'b1};
        endcase
    end

    // Evaluate the jump condition on the current datapath flags
    always_comb
    begin
        case (word.jcond)
            JC_NONE: taken = 1'b0;
            JC_SEL0: taken = !status.sel;
            JC_SEL1: taken = status.sel;
            JC_BAD:  taken = status.bad;
            default: taken = 1'b0;
        endcase
    end

    // Hold the finishing step until the result register is free
    assign stall = (word.op == OP_DONE) && !status.out_free;
    assign load  = req_valid && !busy_reg;

    // Advance the step counter
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (load)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else if (!stall)
        begin
            step_next = taken ? word.target : step_reg + STEP_W'(1);
            if (word.last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign req_ready    = !busy_reg;
    assign ctrl.op      = word.op;
    assign ctrl.sel_ctl = word.sel_ctl;
    assign ctrl.exec    = busy_reg && !stall;
    assign ctrl.load    = load;

endmodule

>>> rtl/wdcb_dp.sv
// Datapath: shared multiplier, divide-by-25 and divide-by-7 fix-up, serial
// day accumulator, week floor accumulator and result register. Uses wdcb_pkg.
`timescale 1ns / 1ps

module wdcb_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  wdcb_pkg::ctrl_t   ctrl,
    input  wdcb_pkg::req_t    req_data,
    output wdcb_pkg::status_t status,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output wdcb_pkg::rsp_t    rsp_data
);
    import wdcb_pkg::*;

    req_t                date_reg;
    logic                sel_reg;
    logic                bad_reg;
    logic [MUL_W-1:0]    mul_reg;
    logic [SERIAL_W-1:0] opnd_reg;
    logic [Q25_W-1:0]    q25_reg;
    logic [R25_W-1:0]    r25_reg;
    logic [SERIAL_W-1:0] acc_reg;
    logic [SERIAL_W-1:0] n0_reg;
    logic [SERIAL_W-1:0] n1_reg;
    logic [Q7_W-1:0]     q7_reg;
    logic [R7_W-1:0]     r7_reg;
    logic [SERIAL_W-1:0] wacc_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    logic [YEAR_W-1:0]   yr;
    logic [MONTH_W-1:0]  mo;
    logic [DAY_W-1:0]    dy;
    logic [YEAR_W-1:0]   yy;
    logic [SERIAL_W-1:0] cur_n;
    logic [SERIAL_W-1:0] mul_a;
    logic [SERIAL_W-1:0] mul_b;
    logic [Q25_W-1:0]    q25_est;
    logic [D25_W-1:0]    r25_full;
    logic [Q25_W-1:0]    q25_fix;
    logic [R25_W-1:0]    r25_fix;
    logic                div4;
    logic                cent;
    logic                leap;
    logic [DAY_W-1:0]    dim;
    logic                date_ok;
    logic [SERIAL_W-1:0] ser_base;
    logic [SERIAL_W-1:0] ser_full;
    logic [Q7_W-1:0]     q7_est;
    logic [SERIAL_W-1:0] r7_full;
    logic [Q7_W-1:0]     q7_fix;
    logic [R7_W-1:0]     r7_fix;
    logic [SERIAL_W-1:0] f_val;

    // Pick the date under work
    assign yr    = sel_reg ? date_reg.second_year  : date_reg.first_year;
    assign mo    = sel_reg ? date_reg.second_month : date_reg.first_month;
    assign dy    = sel_reg ? date_reg.second_day   : date_reg.first_day;
    // January and February count with the previous year
    assign yy    = (mo <= MONTH_W'(2)) ? yr - YEAR_W'(1) : yr;
    assign cur_n = sel_reg ? n1_reg : n0_reg;

    // Select multiplier operands
    always_comb
    begin
        case (ctrl.op)
            OP_LEAP_MUL: mul_a = SERIAL_W'(yr[YEAR_W-1:2]);
            OP_SER_MUL:  mul_a = SERIAL_W'(yy[YEAR_W-1:2]);
            default:     mul_a = cur_n;
        endcase
        mul_b = (ctrl.op == OP_D7_MUL) ? RECIP7 : RECIP25;
    end

    // Divide by 25: estimate from the reciprocal, then one correction
    assign q25_est  = mul_reg[SHIFT25 +: Q25_W];
    assign r25_full = opnd_reg[D25_W-1:0] - D25_W'(SERIAL_W'(q25_est) * DIV25);
    always_comb
    begin
        if (r25_full >= D25_W'(DIV25))
        begin
            q25_fix = q25_est + Q25_W'(1);
            r25_fix = R25_W'(r25_full - D25_W'(DIV25));
        end
        else
        begin
            q25_fix = q25_est;
            r25_fix = R25_W'(r25_full);
        end
    end

    // Leap year from year mod 4 and (year / 4) divided by 25
    assign div4    = (yr[1:0] == 2'd0);
    assign cent    = div4 && (r25_reg == '0);
    assign leap    = (div4 && !cent) || (cent && (q25_reg[1:0] == 2'd0));
    assign dim     = month_days(mo, leap);
    assign date_ok = (yr != '0) && (yr <= MAX_YEAR)
                     && (mo >= MONTH_W'(1)) && (mo <= MONTH_W'(12))
                     && (dy != '0) && (dy <= dim);

    // Serial day number in two adds: year part, then century and month terms
    assign ser_base = SERIAL_W'(yy) * DAYS_YEAR + SERIAL_W'(yy[YEAR_W-1:2]);
    assign ser_full = acc_reg - SERIAL_W'(q25_reg) + SERIAL_W'(q25_reg[Q25_W-1:2])
                      + SERIAL_W'(march_offset(mo)) + SERIAL_W'(dy) + SERIAL_BIAS;

    // Divide by 7: estimate from the reciprocal, then one correction
    assign q7_est  = mul_reg[SHIFT7 +: Q7_W];
    assign r7_full = opnd_reg - SERIAL_W'(q7_est) * DIV7;
    always_comb
    begin
        if (r7_full >= DIV7)
        begin
            q7_fix = q7_est + Q7_W'(1);
            r7_fix = R7_W'(r7_full - DIV7);
        end
        else
        begin
            q7_fix = q7_est;
            r7_fix = R7_W'(r7_full);
        end
    end

    // Weekdays before a biased serial: 5 per week plus the partial week
    assign f_val = SERIAL_W'(q7_reg) * WEEK_DAYS
                   + ((r7_reg == '0) ? '0 : SERIAL_W'(r7_reg - R7_W'(1)));

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            date_reg <= req_data;
        end
        if (ctrl.exec)
        begin
            case (ctrl.op)
                OP_LEAP_MUL, OP_SER_MUL, OP_D7_MUL:
                begin
                    mul_reg  <= MUL_W'(mul_a) * MUL_W'(mul_b);
                    opnd_reg <= mul_a;
                end
                OP_DIV25_FIX:
                begin
                    q25_reg <= q25_fix;
                    r25_reg <= r25_fix;
                end
                OP_SER_BASE:
                begin
                    acc_reg <= ser_base;
                end
                OP_SER_ADD:
                begin
                    if (sel_reg)
                    begin
                        n1_reg <= ser_full;
                    end
                    else
                    begin
                        n0_reg <= ser_full;
                    end
                end
                OP_ORDER:
                begin
                    if (n0_reg > n1_reg)
                    begin
                        n0_reg <= n1_reg;
                        n1_reg <= n0_reg;
                    end
                end
                OP_D7_FIX:
                begin
                    q7_reg <= q7_fix;
                    r7_reg <= r7_fix;
                end
                OP_F_ACC:
                begin
                    wacc_reg <= sel_reg ? f_val : wacc_reg - f_val;
                end
                OP_DONE:
                begin
                    rsp_reg.weekday_total <= bad_reg ? '0 : wacc_reg;
                    rsp_reg.date_invalid  <= bad_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control registers: date select, error flag, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                sel_reg <= 1'b0;
                bad_reg <= 1'b0;
            end
            else if (ctrl.exec)
            begin
                case (ctrl.sel_ctl)
                    SEL_SET:    sel_reg <= 1'b1;
                    SEL_TOGGLE: sel_reg <= !sel_reg;
                    default:    sel_reg <= sel_reg;
                endcase
                if (ctrl.op == OP_CHECK)
                begin
                    bad_reg <= bad_reg || !date_ok;
                end
            end

            if (ctrl.exec && (ctrl.op == OP_DONE))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign status.sel      = sel_reg;
    assign status.bad      = bad_reg;
    assign status.out_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp_data        = rsp_reg;

endmodule

>>> rtl/weekday_count_between_dates_unit.sv
// Counts the Monday-to-Friday days from the earlier of two Gregorian dates
// (inclusive) to the later (exclusive); the dates may come in either order.
// An out-of-range year, month or day in either date flags date_invalid and
// gives a count of 0. One item is in work at a time: a request beat runs
// through the control program (cut short when a date is invalid), one control
// word per cycle unless the finishing step stalls on a full output register,
// over a single shared 22x22 multiplier, and the result beat then waits in its
// output register while the next request is taken.
`timescale 1ns / 1ps
`include "weekday_count_between_dates_unit_assert.svh"

module weekday_count_between_dates_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  wdcb_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output wdcb_pkg::rsp_t rsp_data
);
    import wdcb_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    // Sequencer: control ROM and step counter
    wdcb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    // Datapath and result register
    wdcb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .req_data  (req_data),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // An accepted request starts the program at its first step
    `WDCB_ASSERT_NEXT(a_start_on_accept, req_valid && req_ready,
        !req_ready && ctrl.exec && (ctrl.op == OP_LEAP_MUL))
    // The finishing step never overwrites a result still waiting
    `WDCB_ASSERT_NOW(a_done_slot_free, ctrl.exec && (ctrl.op == OP_DONE),
        !rsp_valid || rsp_ready)
    // A finished item always shows up on the response side
    `WDCB_ASSERT_NEXT(a_done_gives_beat, ctrl.exec && (ctrl.op == OP_DONE), rsp_valid)

endmodule

>>> test/tb_weekday_count_between_dates_unit.sv
// Self-checking testbench for the weekday count unit: directed table, then random date pairs.
// Depends on wdcb_pkg (request and result beat types) and weekday_count_between_dates_unit.
`timescale 1ns / 1ps

module tb_weekday_count_between_dates_unit;

    import wdcb_pkg::*;

    localparam int unsigned RAND_BEATS   = 116;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned LAST_YEAR    = 9999;

    typedef struct {
        req_t beat;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_data;

    rsp_t        weekday_due_q[$];
    dir_row_t    dir_rows[$];
    int unsigned err_count     = 0;
    int unsigned checked_count = 0;
    int unsigned invalid_count = 0;
    int unsigned sent_count    = 0;
    int unsigned cycle_count   = 0;
    bit          quiet_mode    = 1'b0;

    weekday_count_between_dates_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // Free-running clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Calendar helpers for the predictor and the stimulus
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_in_range(input int unsigned y, input int unsigned m,
                                         input int unsigned d);
        return (y >= 1) && (y <= LAST_YEAR) && (m >= 1) && (m <= 12) &&
               (d >= 1) && (d <= month_length(m, y));
    endfunction

    // Continuous day number, years counted from March
    function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned yy;
        int unsigned mp;
        yy = (m <= 2) ? y - 1 : y;
        mp = (m > 2) ? m - 3 : m + 9;
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d - 1;
    endfunction

    // Day of week, Sunday is 0
    function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned a;
        int unsigned yy;
        int unsigned mm;
        a  = (14 - m) / 12;
        yy = y - a;
        mm = m + 12 * a - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    // Expected result beat for one request beat
    function automatic rsp_t predict_weekdays(input req_t r);
        rsp_t        res;
        int unsigned n1;
        int unsigned n2;
        int unsigned span;
        int unsigned start_dow;
        int unsigned total;
        int unsigned wd;
        res = '0;
        if (!date_in_range(r.first_year, r.first_month, r.first_day) ||
            !date_in_range(r.second_year, r.second_month, r.second_day))
        begin
            res.date_invalid = 1'b1;
            return res;
        end
        n1 = day_number(r.first_year, r.first_month, r.first_day);
        n2 = day_number(r.second_year, r.second_month, r.second_day);
        if (n1 <= n2)
        begin
            span      = n2 - n1;
            start_dow = day_of_week(r.first_year, r.first_month, r.first_day);
        end
        else
        begin
            span      = n1 - n2;
            start_dow = day_of_week(r.second_year, r.second_month, r.second_day);
        end
        total = (span / 7) * 5;
        for (int unsigned i = 0; i < span % 7; i++)
        begin
            wd = (start_dow + i) % 7;
            if (wd != 0 && wd != 6)
                total++;
        end
        res.weekday_total = total[SERIAL_W-1:0];
        return res;
    endfunction

    function automatic req_t make_req(input int unsigned y1, input int unsigned m1,
                                      input int unsigned d1, input int unsigned y2,
                                      input int unsigned m2, input int unsigned d2);
        req_t r;
        r.first_year   = y1[YEAR_W-1:0];
        r.first_month  = m1[MONTH_W-1:0];
        r.first_day    = d1[DAY_W-1:0];
        r.second_year  = y2[YEAR_W-1:0];
        r.second_month = m2[MONTH_W-1:0];
        r.second_day   = d2[DAY_W-1:0];
        return r;
    endfunction

    task automatic add_row(input int unsigned y1, input int unsigned m1, input int unsigned d1,
                           input int unsigned y2, input int unsigned m2, input int unsigned d2,
                           input bit typed, input int unsigned total, input bit bad);
        dir_row_t row;
        row.beat               = make_req(y1, m1, d1, y2, m2, d2);
        row.typed              = typed;
        row.want.weekday_total = total[SERIAL_W-1:0];
        row.want.date_invalid  = bad;
        dir_rows.push_back(row);
    endtask

    task automatic rand_date(output int unsigned y, output int unsigned m,
                             output int unsigned d);
        y = $urandom_range(1, LAST_YEAR);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_length(m, y));
    endtask

    // Mostly short gaps, a few long ones; none in a quiet stretch
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Present one request beat after a random gap, hold it until accepted
    task automatic send_beat(input req_t beat, input bit typed, input rsp_t want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= beat;
        do
            @(posedge clk);
        while (!req_ready);
        weekday_due_q.push_back(typed ? want : predict_weekdays(beat));
        sent_count++;
    endtask

    // Stimulus: reset, directed table, random pairs, drain
    initial
    begin
        int unsigned y1, m1, d1, y2, m2, d2;
        int unsigned kind;
        int unsigned sub;
        rsp_t        none;

        none = '0;
        // equal dates, known weeks from Monday Jan 1 2024, Saturday start
        add_row(2024,  3, 15, 2024,  3, 15, 1'b1, 0, 1'b0);
        add_row(2024,  1,  1, 2024,  1,  8, 1'b1, 5, 1'b0);
        add_row(2024,  1,  8, 2024,  1,  1, 1'b1, 5, 1'b0);
        add_row(2024,  1,  6, 2024,  1,  7, 1'b1, 0, 1'b0);
        add_row(   1,  1,  1,    1,  1,  1, 1'b1, 0, 1'b0);
        add_row(9999, 12, 31, 9999, 12, 31, 1'b1, 0, 1'b0);
        // widest span, both orders
        add_row(   1,  1,  1, 9999, 12, 31, 1'b0, 0, 1'b0);
        add_row(9999, 12, 31,    1,  1,  1, 1'b0, 0, 1'b0);
        // leap days, century and year boundaries
        add_row(2024,  2, 28, 2024,  3,  1, 1'b0, 0, 1'b0);
        add_row(2000,  2, 29, 2000,  3,  7, 1'b0, 0, 1'b0);
        add_row(1899, 12, 31, 1900,  3,  1, 1'b0, 0, 1'b0);
        add_row(2023, 12, 29, 2024,  1,  2, 1'b0, 0, 1'b0);
        add_row(2024,  2, 29, 9999, 12, 31, 1'b0, 0, 1'b0);
        // invalid dates: year, month, day range and month length
        add_row(    0,  5, 10, 2020,  1,  1, 1'b1, 0, 1'b1);
        add_row( 2020,  1,  1, 10000, 1,  1, 1'b1, 0, 1'b1);
        add_row(16383, 15, 31, 2020,  1,  1, 1'b1, 0, 1'b1);
        add_row( 2020,  0, 10, 2020,  1,  1, 1'b1, 0, 1'b1);
        add_row( 2020, 13, 10, 2020,  1,  1, 1'b1, 0, 1'b1);
        add_row( 2020,  6,  0, 2020,  1,  1, 1'b1, 0, 1'b1);
        add_row( 2023,  4, 31, 2020,  1,  1, 1'b1, 0, 1'b1);
        add_row( 2023,  2, 29, 2020,  1,  1, 1'b1, 0, 1'b1);
        add_row( 1900,  2, 29, 2020,  1,  1, 1'b1, 0, 1'b1);
        add_row( 2020,  6, 15, 2021,  6,  0, 1'b1, 0, 1'b1);
        add_row(    0,  0,  0, 16383, 15, 31, 1'b1, 0, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        for (int unsigned i = 0; i < RAND_BEATS; i++)
        begin
            // hold off once until every result is back
            if (i == 40)
            begin
                req_valid <= 1'b0;
                while (weekday_due_q.size() != 0)
                    @(posedge clk);
            end
            quiet_mode = (i >= 70 && i < 95);
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                // raw noise over the full field widths
                y1 = $urandom_range(0, 16383);
                m1 = $urandom_range(0, 15);
                d1 = $urandom_range(0, 31);
                y2 = $urandom_range(0, 16383);
                m2 = $urandom_range(0, 15);
                d2 = $urandom_range(0, 31);
            end
            else
            begin
                rand_date(y1, m1, d1);
                sub = $urandom_range(0, 9);
                if (sub <= 3)
                    rand_date(y2, m2, d2);
                else if (sub <= 6)
                begin
                    y2 = y1;
                    m2 = $urandom_range(1, 12);
                    d2 = $urandom_range(1, month_length(m2, y2));
                end
                else if (sub == 7)
                begin
                    y2 = y1;
                    m2 = m1;
                    d2 = d1;
                end
                else
                begin
                    y2 = y1;
                    m2 = m1;
                    d2 = $urandom_range(1, month_length(m2, y2));
                end
            end
            send_beat(make_req(y1, m1, d1, y2, m2, d2), 1'b0, none);
        end
        quiet_mode = 1'b0;

        // drain outstanding results, then let the block settle
        req_valid <= 1'b0;
        while (weekday_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d request beats (%0d directed, %0d random), stalls on both sides.",
                 sent_count, dir_rows.size(), RAND_BEATS);
        $display("Checked %0d result beats, %0d flagged invalid, %0d mismatches.",
                 checked_count, invalid_count, err_count);
        if (err_count == 0 && weekday_due_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls, mostly short, held open in quiet stretches
    initial
    begin
        int unsigned stall;
        int unsigned r;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (quiet_mode || r < 50)
                stall = 0;
            else if (r < 90)
                stall = $urandom_range(1, 4);
            else
                stall = $urandom_range(10, 40);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            checked_count++;
            if (rsp_data.date_invalid)
                invalid_count++;
            if (weekday_due_q.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result beat total=%0d invalid=%0b",
                             rsp_data.weekday_total, rsp_data.date_invalid);
            end
            else
            begin
                want = weekday_due_q.pop_front();
                if (rsp_data.weekday_total !== want.weekday_total ||
                    rsp_data.date_invalid !== want.date_invalid)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("ERROR: beat %0d total exp %0d got %0d, invalid exp %0b got %0b",
                                 checked_count, want.weekday_total, rsp_data.weekday_total,
                                 want.date_invalid, rsp_data.date_invalid);
                end
            end
        end
    end

    // Watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_count, weekday_due_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
